// ----- design/scfr_pkg.sv -----
`timescale 1ns / 1ps
package scfr_pkg;

  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 16;
  localparam int KIND_W     = 3;
  localparam int CFG_IDX_W  = 8;

  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h55;

  localparam logic [BYTE_W-1:0] POS_HUNT   = 8'd0;
  localparam logic [BYTE_W-1:0] POS_SYNC2  = 8'd1;
  localparam logic [BYTE_W-1:0] POS_LENGTH = 8'd2;
  localparam logic [BYTE_W-1:0] POS_BODY   = 8'd3;
  localparam int               STORE_FIRST = 3;
  localparam int               STORE_DEPTH = 7;
  // a length of 255 puts the check byte at position 254
  localparam logic [BYTE_W-1:0] POS_MAX    = 8'd254;

  localparam int               SCALE_W    = 12;
  localparam logic [SCALE_W-1:0] TURN_SCALE = 12'd3755;
  localparam int               PROD_W     = WORD_W + SCALE_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_ID = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BALANCE_ID  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_ID    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_ID     = 8'd3;

  localparam logic [BYTE_W-1:0] VELOCITY_ID_RST = 8'd1;
  localparam logic [BYTE_W-1:0] BALANCE_ID_RST  = 8'd2;
  localparam logic [BYTE_W-1:0] SPEED_ID_RST    = 8'd3;
  localparam logic [BYTE_W-1:0] TURN_ID_RST     = 8'd4;

  typedef enum logic [KIND_W-1:0] {
    KIND_ERROR    = 3'd0,
    KIND_VELOCITY = 3'd1,
    KIND_BALANCE  = 3'd2,
    KIND_SPEED    = 3'd3,
    KIND_TURN     = 3'd4,
    KIND_OTHER    = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [WORD_W-1:0]  value_a;
    logic        [WORD_W-1:0]  raw_b;   // turn rate word or second gain
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- design/scfr_if.sv -----
`timescale 1ns / 1ps
interface scfr_byte_if import scfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scfr_result_if import scfr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [WORD_W-1:0] value_a;
  logic signed [WORD_W-1:0] value_b;
  logic                     beep;
  modport source (output valid, output kind, output value_a, output value_b,
                  output beep, input ready);
  modport sink   (input valid, input kind, input value_a, input value_b,
                  input beep, output ready);
endinterface

interface scfr_cfg_if import scfr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/serial_command_frame_receiver_unit.sv -----
`timescale 1ns / 1ps
// Path: a result word goes from the queue slot written at the edge that takes the check byte,
//   through the scale multiply stage (stage 1 register), to the output register.
// Throughput: one received byte per cycle while the queue is not full; the 4-deep queue holds
//   up to four pending results and rx stalls whenever it is full.
// Reset (rst, synchronous): hunting for header, sum, length and payload bytes zero,
//   command ids back to 1..4, queue and output empty.
module serial_command_frame_receiver_unit import scfr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  scfr_byte_if.sink     rx,
  scfr_cfg_if.sink      cfg,
  scfr_result_if.source result
);

  q_status_t q_status;
  q_entry_t  push_entry;
  q_entry_t  head;
  logic      push;
  logic      pop;

  scfr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .cfg        (cfg),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  scfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  scfr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .result   (result)
  );

endmodule

// ----- design/scfr_front.sv -----
`timescale 1ns / 1ps
module scfr_front import scfr_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  scfr_byte_if.sink       rx,
  scfr_cfg_if.sink        cfg,
  input  q_status_t       q_status,
  output logic            push,
  output q_entry_t        push_entry
);

  logic [BYTE_W-1:0] velocity_id, balance_id, speed_id, turn_id;
  logic [BYTE_W-1:0] pos;
  logic [BYTE_W-1:0] sum;
  logic [BYTE_W-1:0] len;
  logic [BYTE_W-1:0] store [STORE_DEPTH];

  logic              accept;
  logic [BYTE_W-1:0] b;
  logic              in_body;
  logic              in_store;
  logic [BYTE_W-1:0] store_idx;
  logic [BYTE_W-1:0] cmd;

  assign cfg.ready = 1'b1;
  assign rx.ready  = !q_status.full;
  assign accept    = rx.valid && rx.ready;
  assign b         = rx.rx_byte;

  // body byte while position + 1 < length, otherwise this is the check byte
  assign in_body   = ({1'b0, pos} + 9'd1) < {1'b0, len};
  assign in_store  = pos < 8'(STORE_FIRST + STORE_DEPTH);
  assign store_idx = pos - 8'(STORE_FIRST);
  assign cmd       = store[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      velocity_id <= VELOCITY_ID_RST;
      balance_id  <= BALANCE_ID_RST;
      speed_id    <= SPEED_ID_RST;
      turn_id     <= TURN_ID_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_VELOCITY_ID: velocity_id <= cfg.data;
        REG_BALANCE_ID:  balance_id  <= cfg.data;
        REG_SPEED_ID:    speed_id    <= cfg.data;
        REG_TURN_ID:     turn_id     <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_HUNT;
      sum <= '0;
      len <= '0;
      for (int i = 0; i < STORE_DEPTH; i++) store[i] <= '0;
    end else if (accept) begin
      if (pos == POS_HUNT) begin
        if (b == SYNC_FIRST) pos <= POS_SYNC2;
      end else if (pos == POS_SYNC2) begin
        pos <= (b == SYNC_SECOND) ? POS_LENGTH : POS_HUNT;
      end else if (pos == POS_LENGTH) begin
        len <= b;
        sum <= SYNC_FIRST + SYNC_SECOND + b;
        pos <= POS_BODY;
      end else if (in_body) begin
        if (in_store) store[store_idx[2:0]] <= b;
        pos <= pos + 8'd1;
        sum <= sum + b;
      end else begin
        pos <= POS_HUNT;
      end
    end
  end

  assign push = accept && (pos != POS_HUNT) && (pos != POS_SYNC2) &&
                (pos != POS_LENGTH) && !in_body;

  always_comb begin
    push_entry.kind    = KIND_ERROR;
    push_entry.value_a = '0;
    push_entry.raw_b   = '0;
    if (b == sum) begin
      push_entry.value_a = {store[1], store[2]};
      if (cmd == velocity_id) begin
        push_entry.kind  = KIND_VELOCITY;
        push_entry.raw_b = {store[5], store[6]};
      end else begin
        push_entry.raw_b = {store[3], store[4]};
        if (cmd == balance_id)    push_entry.kind = KIND_BALANCE;
        else if (cmd == speed_id) push_entry.kind = KIND_SPEED;
        else if (cmd == turn_id)  push_entry.kind = KIND_TURN;
        else begin
          push_entry.kind    = KIND_OTHER;
          push_entry.value_a = '0;
          push_entry.raw_b   = '0;
        end
      end
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (rst) pos <= POS_MAX)
    else $error("frame position beyond limit");
  a_len_step: assert property (@(posedge clk) disable iff (rst)
    accept && pos == POS_LENGTH |=> pos == POS_BODY)
    else $error("length byte did not move to body");

endmodule

// ----- design/scfr_queue.sv -----
`timescale 1ns / 1ps
module scfr_queue import scfr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  q_entry_t  push_entry,
  input  logic      pop,
  output q_entry_t  head,
  output q_status_t status
);

  q_entry_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QPTR_W:0]   count;

  assign status.full  = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign status.empty = count == '0;
  assign head         = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && status.full))
    else $error("word pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && status.empty))
    else $error("word popped from empty queue");

endmodule

// ----- design/scfr_back.sv -----
`timescale 1ns / 1ps
module scfr_back import scfr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  q_entry_t      head,
  input  q_status_t     q_status,
  output logic          pop,
  scfr_result_if.source result
);

  // stage 1: magnitude times scale
  logic                     s1_valid;
  kind_t                    s1_kind;
  logic signed [WORD_W-1:0] s1_value_a;
  logic        [WORD_W-1:0] s1_pass_b;
  logic                     s1_neg;
  logic        [SCALE_W-1:0] s1_prod_hi;

  logic              head_neg;
  logic [WORD_W-1:0] head_mag;
  logic [PROD_W-1:0] head_prod;
  logic              s1_load, o_load;
  logic [WORD_W-1:0] scaled_b;

  // two's complement negation of 0x8000 leaves 0x8000, the wanted magnitude
  assign head_neg  = head.raw_b[WORD_W-1];
  assign head_mag  = head_neg ? (~head.raw_b + 1'b1) : head.raw_b;
  assign head_prod = PROD_W'(head_mag) * PROD_W'(TURN_SCALE);

  assign o_load  = s1_valid && (!result.valid || result.ready);
  assign s1_load = !q_status.empty && (!s1_valid || o_load);
  assign pop     = s1_load;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (s1_load) s1_valid <= 1'b1;
    else if (o_load) s1_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_kind    <= head.kind;
      s1_value_a <= head.value_a;
      s1_pass_b  <= head.raw_b;
      s1_neg     <= head_neg;
      s1_prod_hi <= head_prod[PROD_W-1:WORD_W];
    end
  end

  assign scaled_b = s1_neg ? (~WORD_W'(s1_prod_hi) + 1'b1) : WORD_W'(s1_prod_hi);

  always_ff @(posedge clk) begin
    if (rst) result.valid <= 1'b0;
    else if (o_load) result.valid <= 1'b1;
    else if (result.ready) result.valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      result.kind    <= s1_kind;
      result.value_a <= s1_value_a;
      result.value_b <= (s1_kind == KIND_VELOCITY) ? scaled_b : s1_pass_b;
      result.beep    <= (s1_kind != KIND_ERROR) && (s1_kind != KIND_VELOCITY);
    end
  end

  a_beep_kind: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.beep |->
      result.kind != KIND_ERROR && result.kind != KIND_VELOCITY)
    else $error("beep on error or velocity word");
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.kind == KIND_ERROR |->
      result.value_a == '0 && result.value_b == '0 && !result.beep)
    else $error("checksum error word carries data");

endmodule
